/* hw/rtl/bbpt_pkg.sv */
package bbpt_pkg;

  // Field widths
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  // Largest coordinate range the point fields can carry
  localparam int unsigned COORD_LIMIT = 4096;

  // Points one pixel can cause at most
  localparam int unsigned NUM_PTS     = 3;

  // Reset value of both image dimensions
  localparam logic [CFG_W-1:0] DIM_RESET = 13'd64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  // One column of the line store: zero flags of the newest row and the row before it
  typedef struct packed {
    logic prev_zero;
    logic older_zero;
  } line_word_t;

  // One boundary point
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

endpackage

/* hw/rtl/bbpt_line_store.sv */
module bbpt_line_store
  import bbpt_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_a_i,
  input  logic [ADDR_W-1:0] rd_addr_b_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  line_word_t        wr_data_i,
  output line_word_t        rd_data_a_o,
  output line_word_t        rd_data_b_o
);

  line_word_t mem [DEPTH];

  line_word_t rd_a_q, rd_b_q, byp_data_q;
  logic       byp_a_q, byp_b_q;

  // Write one column, read two; note a same-cycle write to a read address
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q     <= mem[rd_addr_a_i];
      rd_b_q     <= mem[rd_addr_b_i];
      byp_a_q    <= wr_en_i && (wr_addr_i == rd_addr_a_i);
      byp_b_q    <= wr_en_i && (wr_addr_i == rd_addr_b_i);
      byp_data_q <= wr_data_i;
    end
  end

  // Forward the colliding write over the stale read
  assign rd_data_a_o = byp_a_q ? byp_data_q : rd_a_q;
  assign rd_data_b_o = byp_b_q ? byp_data_q : rd_b_q;

endmodule

/* hw/rtl/binary_boundary_pixel_trace_top.sv */
// Boundary pixel extraction on a thresholded image, 4-neighbour rule.
// Input channel: one pixel per beat (pixel_value_i) in raster order, zero is black.
// Output channel: one boundary point per beat (point_x_o, point_y_o); last_of_run_o
// marks the final point caused by one input pixel. Pixels that cause no point
// produce no beat.
// Configuration channel: index 0 sets the image width, index 1 the height; write it
// only while the block is idle. Both dimensions reset to 64.
// An accepted pixel is registered in the decision stage; its points are then loaded
// into the output stage, which offers them. Throughput: one pixel per cycle while
// the receiver keeps up and pixels cause at most one point, set by the two-read,
// one-write line store and a one-point output stage. Rows before the last cause at
// most one point per pixel; last-row pixels cause up to two, the frame's final
// pixel up to three, and the decision stage holds while extra points drain.
// Reset clears the column and row counters and the configuration; the line store is
// not cleared, as each row overwrites it before it is read.
// When the receiver stalls, the pending point holds, the decision stage fills, and
// in_ready_o drops until points drain; no point is lost or repeated.
module binary_boundary_pixel_trace_top
  import bbpt_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     pixel_value_i,
  // point output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [COORD_W-1:0]   point_x_o,
  output logic [COORD_W-1:0]   point_y_o,
  output logic                 last_of_run_o,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WIDTH_LIM = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;

  // Configuration
  logic [CFG_W-1:0] width_q, height_q;
  logic [CFG_W-1:0] w_used, h_used;
  logic [COORD_W-1:0] w_last, h_last;

  // Raster position of the next pixel
  logic [COORD_W-1:0] col_q, row_q;
  logic [COORD_W:0]   col_inc;
  logic               in_fire, in_lcol, in_lrow;

  // Decision stage
  logic               s1_valid_q;
  logic [COORD_W-1:0] s1_x_q, s1_y_q;
  logic               s1_cur_q, s1_lcol_q, s1_lrow_q;
  logic               s1_adv;

  // Recent history of the current row and of the row above
  logic cur_d1_q, cur_d2_q, c_d1_q;

  // Line store
  line_word_t word_x, word_x1, wr_word;

  // Decisions
  logic [NUM_PTS-1:0] hit;
  point_t             cand [NUM_PTS];
  point_t             load_pt [NUM_PTS];
  logic [1:0]         hit_cnt;
  logic               x_ge1, x_ge2, y_ge1, y_ge2;
  logic               c_a, u_a, l_a, r_a;
  logic               c_b, u_b, l_b;
  logic               u_c, l_c;

  // Output stage
  logic [1:0] s2_cnt_q;
  point_t     s2_pt_q [NUM_PTS];
  logic       out_fire, s2_free;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Saturate the dimensions into their usable range
  always_comb begin
    if (width_q == '0) begin
      w_used = CFG_W'(1);
    end else if (width_q > CFG_W'(WIDTH_LIM)) begin
      w_used = CFG_W'(WIDTH_LIM);
    end else begin
      w_used = width_q;
    end
    if (height_q == '0) begin
      h_used = CFG_W'(1);
    end else if (height_q > CFG_W'(COORD_LIMIT)) begin
      h_used = CFG_W'(COORD_LIMIT);
    end else begin
      h_used = height_q;
    end
  end

  assign w_last  = COORD_W'(w_used - CFG_W'(1));
  assign h_last  = COORD_W'(h_used - CFG_W'(1));
  assign in_lcol = col_q >= w_last;
  assign in_lrow = row_q >= h_last;
  assign col_inc = {1'b0, col_q} + {{COORD_W{1'b0}}, 1'b1};

  // Handshakes
  assign out_fire   = out_valid_o && out_ready_i;
  assign s2_free    = (s2_cnt_q == 2'd0) || (out_fire && s2_cnt_q == 2'd1);
  assign s1_adv     = s1_valid_q && ((hit_cnt == 2'd0) || s2_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Advance the raster counters on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_lcol) begin
          col_q <= '0;
          row_q <= in_lrow ? '0 : row_q + COORD_W'(1);
        end else begin
          col_q <= col_inc[COORD_W-1:0];
        end
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Load the decision stage and keep the row history
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q    <= col_q;
      s1_y_q    <= row_q;
      s1_cur_q  <= (pixel_value_i == '0);
      s1_lcol_q <= in_lcol;
      s1_lrow_q <= in_lrow;
    end
    if (s1_adv) begin
      cur_d1_q <= s1_cur_q;
      cur_d2_q <= cur_d1_q;
      c_d1_q   <= word_x.prev_zero;
    end
  end

  // Shift the column: newest row moves to older, the current pixel enters newest
  assign wr_word.prev_zero  = s1_cur_q;
  assign wr_word.older_zero = word_x.prev_zero;

  bbpt_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .rd_addr_a_i (ADDR_W'(col_q)),
    .rd_addr_b_i (ADDR_W'(col_inc)),
    .wr_en_i     (s1_adv),
    .wr_addr_i   (ADDR_W'(s1_x_q)),
    .wr_data_i   (wr_word),
    .rd_data_a_o (word_x),
    .rd_data_b_o (word_x1)
  );

  // Decide the pixel above, on the last row the pixel to the left and, at frame end, the pixel itself
  assign x_ge1 = s1_x_q != '0;
  assign x_ge2 = s1_x_q > COORD_W'(1);
  assign y_ge1 = s1_y_q != '0;
  assign y_ge2 = s1_y_q > COORD_W'(1);

  assign c_a = word_x.prev_zero;
  assign u_a = y_ge2 && word_x.older_zero;
  assign l_a = x_ge1 && c_d1_q;
  assign r_a = !s1_lcol_q && word_x1.prev_zero;

  assign c_b = cur_d1_q;
  assign u_b = y_ge1 && c_d1_q;
  assign l_b = x_ge2 && cur_d2_q;

  assign u_c = y_ge1 && word_x.prev_zero;
  assign l_c = x_ge1 && cur_d1_q;

  assign hit[0] = y_ge1 && !c_a && (u_a || s1_cur_q || l_a || r_a);
  assign hit[1] = s1_lrow_q && x_ge1 && !c_b && (u_b || l_b || s1_cur_q);
  assign hit[2] = s1_lrow_q && s1_lcol_q && !s1_cur_q && (u_c || l_c);

  assign cand[0] = '{x: s1_x_q, y: s1_y_q - COORD_W'(1)};
  assign cand[1] = '{x: s1_x_q - COORD_W'(1), y: s1_y_q};
  assign cand[2] = '{x: s1_x_q, y: s1_y_q};

  // Pack the found points in order
  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    for (int i = 0; i < NUM_PTS; i++) begin
      load_pt[i] = '0;
    end
    for (int i = 0; i < NUM_PTS; i++) begin
      if (hit[i]) begin
        load_pt[k] = cand[i];
        k          = k + 2'd1;
      end
    end
    hit_cnt = k;
  end

  // Hold the point count; load a new run or drop the point just sent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_cnt_q <= 2'd0;
    end else if (s1_adv && hit_cnt != 2'd0) begin
      s2_cnt_q <= hit_cnt;
    end else if (out_fire) begin
      s2_cnt_q <= s2_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && hit_cnt != 2'd0) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        s2_pt_q[i] <= load_pt[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < NUM_PTS - 1; i++) begin
        s2_pt_q[i] <= s2_pt_q[i+1];
      end
    end
  end

  assign out_valid_o   = s2_cnt_q != 2'd0;
  assign point_x_o     = s2_pt_q[0].x;
  assign point_y_o     = s2_pt_q[0].y;
  assign last_of_run_o = s2_cnt_q == 2'd1;

  // A run that is not finished keeps offering points
  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_of_run_o |=> out_valid_o)
    else $error("point run broken before its last beat");

  // The first row of a frame that is not the last row finds no point
  a_first_row_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_y_q == '0 && !s1_lrow_q |-> hit_cnt == 2'd0)
    else $error("point found while only the first row is known");

  // A stalled decision stage keeps its pixel
  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_x_q) && $stable(s1_y_q))
    else $error("decision stage lost its pixel while stalled");

  // Only a last-row pixel can cause more than one point
  a_multi_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && hit_cnt > 2'd1 |-> s1_lrow_q)
    else $error("several points from a pixel outside the last row");

endmodule
